// ===== design/apt_pkg.sv =====
package apt_pkg;

    // Angle resolution: 2^ANGLE_BITS steps per full turn.
    localparam int ANGLE_BITS  = 12;
    localparam int ANG_QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int ANG_EIGHTH  = 1 << (ANGLE_BITS - 3);

    // Quarter-wave table, indices 0..ANG_QUARTER, split into banks.
    localparam int IDX_BITS = ANGLE_BITS - 1;
    localparam int MAG_W    = 15;
    localparam int TRIG_W   = MAG_W + 1;
    localparam int CHUNK_W  = (IDX_BITS - 1 < 8) ? IDX_BITS - 1 : 8;
    localparam int CHUNK_N  = 1 << CHUNK_W;
    localparam int CHUNKS   = (ANG_QUARTER + CHUNK_N) / CHUNK_N;
    localparam int SEL_W    = IDX_BITS - CHUNK_W;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd4;

    localparam logic signed [15:0] SCALE_ONE = 16'sd256;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
    } t_cfg;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } t_trig;

    typedef logic [CHUNKS-1:0][CHUNK_N-1:0][MAG_W-1:0] t_ctab;

    // Table generation, elaboration only. Angles in Q62 radians.
    localparam logic [63:0] PI4_Q62      = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_LSB     = 64'h0000_8000_0000_0000;
    localparam logic [63:0] ANG_EIGHTH_W = 64'(ANG_EIGHTH);

    function automatic logic [63:0] mq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] step_angle(input int u);
        logic [63:0] uu;
        uu = 64'(u);
        return (PI4_Q62 / ANG_EIGHTH_W) * uu + ((PI4_Q62 % ANG_EIGHTH_W) * uu) / ANG_EIGHTH_W;
    endfunction

    function automatic logic [63:0] series_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mq(x, x);
        term = x;
        sum  = x;
        term = mq(term, x2) / 64'd6;    sum = sum - term;
        term = mq(term, x2) / 64'd20;   sum = sum + term;
        term = mq(term, x2) / 64'd42;   sum = sum - term;
        term = mq(term, x2) / 64'd72;   sum = sum + term;
        term = mq(term, x2) / 64'd110;  sum = sum - term;
        term = mq(term, x2) / 64'd156;  sum = sum + term;
        term = mq(term, x2) / 64'd210;  sum = sum - term;
        term = mq(term, x2) / 64'd272;  sum = sum + term;
        term = mq(term, x2) / 64'd342;  sum = sum - term;
        term = mq(term, x2) / 64'd420;  sum = sum + term;
        term = mq(term, x2) / 64'd506;  sum = sum - term;
        term = mq(term, x2) / 64'd600;  sum = sum + term;
        term = mq(term, x2) / 64'd702;  sum = sum - term;
        term = mq(term, x2) / 64'd812;  sum = sum + term;
        term = mq(term, x2) / 64'd930;  sum = sum - term;
        term = mq(term, x2) / 64'd1056; sum = sum + term;
        term = mq(term, x2) / 64'd1190; sum = sum - term;
        term = mq(term, x2) / 64'd1332; sum = sum + term;
        term = mq(term, x2) / 64'd1482; sum = sum - term;
        term = mq(term, x2) / 64'd1640; sum = sum + term;
        term = mq(term, x2) / 64'd1806; sum = sum - term;
        term = mq(term, x2) / 64'd1980; sum = sum + term;
        term = mq(term, x2) / 64'd2162; sum = sum - term;
        return sum;
    endfunction

    function automatic logic [63:0] series_cos(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mq(x, x);
        term = ONE_Q62;
        sum  = ONE_Q62;
        term = mq(term, x2) / 64'd2;    sum = sum - term;
        term = mq(term, x2) / 64'd12;   sum = sum + term;
        term = mq(term, x2) / 64'd30;   sum = sum - term;
        term = mq(term, x2) / 64'd56;   sum = sum + term;
        term = mq(term, x2) / 64'd90;   sum = sum - term;
        term = mq(term, x2) / 64'd132;  sum = sum + term;
        term = mq(term, x2) / 64'd182;  sum = sum - term;
        term = mq(term, x2) / 64'd240;  sum = sum + term;
        term = mq(term, x2) / 64'd306;  sum = sum - term;
        term = mq(term, x2) / 64'd380;  sum = sum + term;
        term = mq(term, x2) / 64'd462;  sum = sum - term;
        term = mq(term, x2) / 64'd552;  sum = sum + term;
        term = mq(term, x2) / 64'd650;  sum = sum - term;
        term = mq(term, x2) / 64'd756;  sum = sum + term;
        term = mq(term, x2) / 64'd870;  sum = sum - term;
        term = mq(term, x2) / 64'd992;  sum = sum + term;
        term = mq(term, x2) / 64'd1122; sum = sum - term;
        term = mq(term, x2) / 64'd1260; sum = sum + term;
        term = mq(term, x2) / 64'd1406; sum = sum - term;
        term = mq(term, x2) / 64'd1560; sum = sum + term;
        term = mq(term, x2) / 64'd1722; sum = sum - term;
        term = mq(term, x2) / 64'd1892; sum = sum + term;
        term = mq(term, x2) / 64'd2070; sum = sum - term;
        return sum;
    endfunction

    // round(16384*sin) for first-quadrant step u
    function automatic logic [MAG_W-1:0] quarter_sin(input int u);
        logic [63:0] s;
        logic [63:0] r;
        if (u <= ANG_EIGHTH) begin
            s = series_sin(step_angle(u));
        end else begin
            s = series_cos(step_angle(ANG_QUARTER - u));
        end
        r = s + HALF_LSB;
        return r[62:48];
    endfunction

    function automatic t_ctab build_ctab();
        t_ctab tab;
        int    u;
        tab = '0;
        for (int c = 0; c < CHUNKS; c++) begin
            for (int j = 0; j < CHUNK_N; j++) begin
                u = c * CHUNK_N + j;
                if (u <= ANG_QUARTER) begin
                    tab[c][j] = quarter_sin(u);
                end
            end
        end
        return tab;
    endfunction

    localparam t_ctab CTAB = build_ctab();

endpackage

// ===== design/apt_trig.sv =====
module apt_trig (
    input  logic                          i_clk,
    input  logic [apt_pkg::ANGLE_BITS-1:0] i_angle,
    output apt_pkg::t_trig                o_trig
);
    import apt_pkg::*;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        logic                neg;
    } t_lut;

    // Fold a binary angle onto the quarter-wave table.
    function automatic t_lut quad_index(input logic [ANGLE_BITS-1:0] k);
        t_lut                  res;
        logic [ANGLE_BITS-3:0] r;
        r       = k[ANGLE_BITS-3:0];
        res.neg = k[ANGLE_BITS-1];
        res.idx = k[ANGLE_BITS-2] ? (IDX_BITS'(ANG_QUARTER) - IDX_BITS'(r)) : IDX_BITS'(r);
        return res;
    endfunction

    t_lut lut_s;
    t_lut lut_c;

    logic [MAG_W-1:0] r_part_s [CHUNKS];
    logic [MAG_W-1:0] r_part_c [CHUNKS];
    logic [SEL_W-1:0] r_sel_s;
    logic [SEL_W-1:0] r_sel_c;
    logic             r_neg_s;
    logic             r_neg_c;
    logic [MAG_W-1:0] mag_s;
    logic [MAG_W-1:0] mag_c;
    t_trig            r_trig;

    assign lut_s = quad_index(i_angle);
    assign lut_c = quad_index(i_angle + ANGLE_BITS'(ANG_QUARTER));

    // stage 1: one read per table bank
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CHUNKS; c++) begin
            r_part_s[c] <= CTAB[c][lut_s.idx[CHUNK_W-1:0]];
            r_part_c[c] <= CTAB[c][lut_c.idx[CHUNK_W-1:0]];
        end
        r_sel_s <= lut_s.idx[IDX_BITS-1:CHUNK_W];
        r_sel_c <= lut_c.idx[IDX_BITS-1:CHUNK_W];
        r_neg_s <= lut_s.neg;
        r_neg_c <= lut_c.neg;
    end

    // stage 2: bank select and sign
    always_comb begin
        mag_s = '0;
        mag_c = '0;
        for (int c = 0; c < CHUNKS; c++) begin
            if (r_sel_s == SEL_W'(c)) begin
                mag_s = r_part_s[c];
            end
            if (r_sel_c == SEL_W'(c)) begin
                mag_c = r_part_c[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_trig.sin_v <= r_neg_s ? -{1'b0, mag_s} : {1'b0, mag_s};
        r_trig.cos_v <= r_neg_c ? -{1'b0, mag_c} : {1'b0, mag_c};
    end

    assign o_trig = r_trig;

endmodule

// ===== design/apt_pipe.sv =====
module apt_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  apt_pkg::t_cfg      i_cfg,
    input  apt_pkg::t_trig     i_trig,
    output logic               o_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_saturated
);
    import apt_pkg::*;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // coefficient stage, follows the config registers
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] nsin_v;
    logic signed [15:0]       sx;
    logic signed [15:0]       sy;
    logic signed [31:0]       p_ca;
    logic signed [31:0]       p_cb;
    logic signed [31:0]       p_cc;
    logic signed [31:0]       p_cd;
    logic signed [31:0]       tx;
    logic signed [31:0]       ty;

    logic signed [16:0] r_ca;
    logic signed [16:0] r_cb;
    logic signed [16:0] r_cc;
    logic signed [16:0] r_cd;

    assign cos_v  = i_trig.cos_v;
    assign sin_v  = i_trig.sin_v;
    assign nsin_v = -sin_v;
    assign sx     = i_cfg.sx;
    assign sy     = i_cfg.sy;
    assign tx     = i_cfg.tx;
    assign ty     = i_cfg.ty;
    assign p_ca   = 32'(cos_v) * 32'(sx);
    assign p_cb   = 32'(nsin_v) * 32'(sy);
    assign p_cc   = 32'(sin_v) * 32'(sx);
    assign p_cd   = 32'(cos_v) * 32'(sy);

    always_ff @(posedge i_clk) begin
        r_ca <= p_ca[30:14];
        r_cb <= p_cb[30:14];
        r_cc <= p_cc[30:14];
        r_cd <= p_cd[30:14];
    end

    // item pipeline
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_v4;
    logic               r_vo;
    logic signed [31:0] r1_px;
    logic signed [31:0] r1_py;
    logic signed [48:0] r2_pa;
    logic signed [48:0] r2_pb;
    logic signed [48:0] r2_pc;
    logic signed [48:0] r2_pd;
    logic signed [41:0] r3_sx;
    logic signed [41:0] r3_sy;
    logic signed [42:0] r4_nx;
    logic signed [42:0] r4_ny;
    logic [31:0]        r_out_x;
    logic [31:0]        r_out_y;
    logic               r_sat;

    logic        hi_x;
    logic        lo_x;
    logic        hi_y;
    logic        lo_y;
    logic [31:0] n_out_x;
    logic [31:0] n_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vo <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_px <= i_point_x;
        r1_py <= i_point_y;
        r2_pa <= 49'(r1_px) * 49'(r_ca);
        r2_pb <= 49'(r1_py) * 49'(r_cb);
        r2_pc <= 49'(r1_px) * 49'(r_cc);
        r2_pd <= 49'(r1_py) * 49'(r_cd);
        r3_sx <= {r2_pa[48], r2_pa[48:8]} + {r2_pb[48], r2_pb[48:8]};
        r3_sy <= {r2_pc[48], r2_pc[48:8]} + {r2_pd[48], r2_pd[48:8]};
        r4_nx <= {r3_sx[41], r3_sx} + {{11{tx[31]}}, tx};
        r4_ny <= {r3_sy[41], r3_sy} + {{11{ty[31]}}, ty};
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
        r_sat   <= hi_x | lo_x | hi_y | lo_y;
    end

    // clamp to 32 bits
    always_comb begin
        hi_x = !r4_nx[42] && (r4_nx[41:31] != '0);
        lo_x =  r4_nx[42] && (r4_nx[41:31] != '1);
        hi_y = !r4_ny[42] && (r4_ny[41:31] != '0);
        lo_y =  r4_ny[42] && (r4_ny[41:31] != '1);
        n_out_x = hi_x ? SAT_MAX : (lo_x ? SAT_MIN : r4_nx[31:0]);
        n_out_y = hi_y ? SAT_MAX : (lo_y ? SAT_MIN : r4_ny[31:0]);
    end

    assign o_valid     = r_vo;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_saturated = r_sat;

    a_valid_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, 5))
        else $error("result strobe without an item five cycles earlier");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (r_out_x == SAT_MAX || r_out_x == SAT_MIN ||
                                      r_out_y == SAT_MAX || r_out_y == SAT_MIN))
        else $error("saturated flag set but no coordinate at a limit");

endmodule

// ===== design/affine_point_transform_2d.sv =====
// Results strobe o_valid after capture, products, pair sum, translation, clamp.
// Throughput: one item per cycle unless busy, which follows a rotation write or reset.
// Busy is held after each rotation write and after reset while the sine/cosine lookup
// (2 table stages) and coefficient multiply settle.
// Reset (synchronous, active low) sets translation 0, rotation 0, scale 1.0 on both axes.
// Results cannot be held off: each one is valid for exactly one cycle.
module affine_point_transform_2d (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [31:0]                i_point_x,
    input  logic signed [31:0]                i_point_y,
    input  logic                              i_cfg_we,
    input  logic [apt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [apt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_valid,
    output logic signed [31:0]                o_out_x,
    output logic signed [31:0]                o_out_y,
    output logic                              o_saturated
);
    import apt_pkg::*;

    // Cycles the coefficient path needs after the angle changes:
    // table bank read, bank select/sign, coefficient multiply.
    localparam logic [1:0] REFRESH_CYCLES = 2'd3;

    // Configuration registers
    logic signed [31:0]      r_tx;
    logic signed [31:0]      r_ty;
    logic [ANGLE_BITS-1:0]   r_angle;
    logic signed [15:0]      r_sx;
    logic signed [15:0]      r_sy;
    logic [1:0]              r_refresh;

    logic signed [31:0]      n_tx;
    logic signed [31:0]      n_ty;
    logic [ANGLE_BITS-1:0]   n_angle;
    logic signed [15:0]      n_sx;
    logic signed [15:0]      n_sy;
    logic [1:0]              n_refresh;

    logic   accept;
    t_cfg   cfg;
    t_trig  trig;

    // Register writes; indices past the list fall to default and are ignored.
    always_comb begin
        n_tx      = r_tx;
        n_ty      = r_ty;
        n_angle   = r_angle;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_refresh = (r_refresh != 2'd0) ? r_refresh - 2'd1 : 2'd0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TRANSLATE_X: n_tx = i_cfg_data[31:0];
                REG_TRANSLATE_Y: n_ty = i_cfg_data[31:0];
                REG_ROTATION: begin
                    // only the low angle bits matter; restart the settle window
                    n_angle   = i_cfg_data[ANGLE_BITS-1:0];
                    n_refresh = REFRESH_CYCLES;
                end
                REG_SCALE_X: n_sx = i_cfg_data[15:0];
                REG_SCALE_Y: n_sy = i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx      <= '0;
            r_ty      <= '0;
            r_angle   <= '0;
            r_sx      <= SCALE_ONE;
            r_sy      <= SCALE_ONE;
            r_refresh <= REFRESH_CYCLES;
        end else begin
            r_tx      <= n_tx;
            r_ty      <= n_ty;
            r_angle   <= n_angle;
            r_sx      <= n_sx;
            r_sy      <= n_sy;
            r_refresh <= n_refresh;
        end
    end

    // Scale and translation reach the datapath directly: a scale write lands in
    // the coefficient registers in the following cycle, before any new item needs them.
    assign busy   = (r_refresh != 2'd0);
    assign accept = start && !busy;

    assign cfg.tx = r_tx;
    assign cfg.ty = r_ty;
    assign cfg.sx = r_sx;
    assign cfg.sy = r_sy;

    // Sine/cosine of the current angle, two register stages
    apt_trig u_trig (
        .i_clk   (i_clk),
        .i_angle (r_angle),
        .o_trig  (trig)
    );

    // Coefficients plus the five-stage point pipeline:
    // capture, products, pair sum, translation, clamp.
    apt_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_cfg       (cfg),
        .i_trig      (trig),
        .o_valid     (o_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_saturated (o_saturated)
    );

    // A rotation write must block new items while the table output settles.
    a_refresh_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == REG_ROTATION) |=> busy ##1 busy ##1 busy)
        else $error("item window opened before rotation coefficients settled");

    // Every accepted item yields exactly one result on o_valid.
    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted item produced no result");

endmodule
